// ===== rtl/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared widths, codes and types of the PID controller with anti-windup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int DATA_W    = 16;
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int INTEG_W   = 48;
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 17;
    localparam int DIV_N_W   = 48;
    localparam int DIV_D_W   = 16;
    localparam int SUM_W     = 50;
    localparam int ADDR_W    = 5;
    localparam int PDATA_W   = 32;

    localparam logic [DATA_W-1:0] DT_DEFAULT = 16'd655;   // about 0.01 s in Q0.16

    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        REG_GAIN_P  = 3'd0,
        REG_GAIN_I  = 3'd1,
        REG_GAIN_D  = 3'd2,
        REG_OUT_MIN = 3'd3,
        REG_OUT_MAX = 3'd4
    } reg_addr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ED,
        ST_MUL_I,
        ST_DIV_I,
        ST_MUL_P,
        ST_MUL_D,
        ST_DIV_D,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] measurement;
        logic        [DATA_W-1:0] step_time;
    } step_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     saturated;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/pidaw_mul.sv =====
// ----------------------------------------------------------------------------
// pidaw_mul
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pidaw_mul #(
    parameter int AW = pidaw_pkg::MUL_A_W,
    parameter int BW = pidaw_pkg::MUL_B_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [AW-1:0]       a,
    input  logic signed [BW-1:0]       b,
    output pidaw_pkg::unit_stat_t      stat,
    output logic signed [AW+BW-1:0]    prod
);

    localparam int PW   = AW + BW;
    localparam int CntW = $clog2(BW);

    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] mcand_reg, mcand_next;
    logic        [BW-1:0] mplier_reg, mplier_next;
    logic      [CntW-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 last;
    logic signed [PW-1:0] term;

    assign last = (cnt_reg == CntW'(BW - 1));
    assign term = mplier_reg[0] ? mcand_reg : '0;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = PW'(a);
            mplier_next = b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            // top multiplier bit carries negative weight
            acc_next    = last ? (acc_reg - term) : (acc_reg + term);
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + CntW'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

// ===== rtl/pidaw_div.sv =====
// ----------------------------------------------------------------------------
// pidaw_div
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidaw_div #(
    parameter int NW = pidaw_pkg::DIV_N_W,
    parameter int DW = pidaw_pkg::DIV_D_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NW-1:0]         n,
    input  logic [DW-1:0]         d,
    output pidaw_pkg::unit_stat_t stat,
    output logic [NW-1:0]         q
);

    localparam int CntW = $clog2(NW);

    logic   [NW-1:0] q_reg, q_next;
    logic   [DW-1:0] rem_reg, rem_next;
    logic   [DW-1:0] d_reg, d_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            last;
    logic     [DW:0] trial;
    logic     [DW:0] diff;
    logic            ge;

    assign last  = (cnt_reg == CntW'(NW - 1));
    assign trial = {rem_reg, q_reg[NW-1]};
    assign ge    = (trial >= {1'b0, d_reg});
    assign diff  = trial - {1'b0, d_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = n;
            rem_next  = '0;
            d_next    = d;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            q_next   = {q_reg[NW-2:0], ge};
            cnt_next = cnt_reg + CntW'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign q         = q_reg;

endmodule

// ===== rtl/pid_controller_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// PID step with saturating integrator, integral clamp and output clamp.
// ----------------------------------------------------------------------------
// Usage:
//   step channel (step_valid/step_stall/step) carries one control item: a
//   compute op with setpoint, measurement and dt, or a clear op.
//   result channel (result_valid/result_stall/result) returns one item per
//   step item: drive and the saturated flag. The user must write gains
//   and limits over the APB port while the block is idle (not enforced).
// Sequence:
//   A compute item runs four bit-serial multiplies (err*dt, ki*integrator,
//   kp*err, kd*diff) and one bit-serial division by dt. When the integral
//   term clamps with ki > 0 the integrator rewrite adds a second division
//   (limit by ki). A clear item runs neither a multiply nor a division.
//   One item is worked on at a time; step_stall is high while it is.
// Reset clears integrator, previous error, gains (0) and limits (full range).
// A held result stays on result while result_stall is high; the next item
// may be accepted meanwhile and waits at its end until the result is taken.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step_valid,
    output logic                                 step_stall,
    input  pidaw_pkg::step_t                     step,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output pidaw_pkg::result_t                   result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pidaw_pkg::ADDR_W-1:0]         paddr,
    input  logic [pidaw_pkg::PDATA_W-1:0]        pwdata,
    output logic [pidaw_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready
);

    localparam int DataW  = pidaw_pkg::DATA_W;
    localparam int ErrW   = pidaw_pkg::ERR_W;
    localparam int DiffW  = pidaw_pkg::DIFF_W;
    localparam int IntegW = pidaw_pkg::INTEG_W;
    localparam int MulAW  = pidaw_pkg::MUL_A_W;
    localparam int MulBW  = pidaw_pkg::MUL_B_W;
    localparam int MulPW  = MulAW + MulBW;
    localparam int DivNW  = pidaw_pkg::DIV_N_W;
    localparam int DivDW  = pidaw_pkg::DIV_D_W;
    localparam int SumW   = pidaw_pkg::SUM_W;
    localparam int PdataW = pidaw_pkg::PDATA_W;

    localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
    localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};

    // configuration
    logic signed [DataW-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DataW-1:0] out_min_reg, out_max_reg;
    logic                    cfg_wr;
    pidaw_pkg::reg_addr_t    cfg_addr;

    // sequencer and datapath
    pidaw_pkg::seq_state_t    state_reg, state_next;
    logic signed [ErrW-1:0]   err_reg, err_next;
    logic        [DataW-1:0]  dt_reg, dt_next;
    logic signed [IntegW-1:0] integ_reg, integ_next;
    logic signed [ErrW-1:0]   last_err_reg, last_err_next;
    logic signed [SumW-1:0]   sum_reg, sum_next;
    logic                     quo_neg_reg, quo_neg_next;
    logic                     clr_reg, clr_next;
    pidaw_pkg::result_t       result_reg, result_next;
    logic                     result_valid_reg, result_valid_next;

    // arithmetic units
    logic                     mul_start;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [MulPW-1:0]  mul_prod;
    pidaw_pkg::unit_stat_t    mul_stat;
    logic                     div_start;
    logic        [DivNW-1:0]  div_n;
    logic        [DivDW-1:0]  div_d;
    logic        [DivNW-1:0]  div_q;
    pidaw_pkg::unit_stat_t    div_stat;

    // combinational helpers
    logic signed [ErrW-1:0]   step_err;
    logic        [DataW-1:0]  step_dt;
    logic signed [IntegW:0]   integ_sum;
    logic signed [IntegW-1:0] integ_sat;
    logic signed [MulPW-1:0]  i_hi_lim, i_lo_lim;
    logic                     i_hi, i_lo;
    logic signed [DataW-1:0]  i_lim;
    logic        [DataW-1:0]  i_lim_abs;
    logic                     gain_i_pos;
    logic signed [DiffW-1:0]  diff;
    logic signed [MulPW-1:0]  pd_abs;
    logic signed [SumW-1:0]   d8;
    logic signed [SumW-1:0]   max256, min256, s1, s2;
    logic                     sum_hi, sum_lo;

    pidaw_mul #(
        .AW (MulAW),
        .BW (MulBW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    pidaw_div #(
        .NW (DivNW),
        .DW (DivDW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .stat  (div_stat),
        .q     (div_q)
    );

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_addr = pidaw_pkg::reg_addr_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            out_min_reg <= {1'b1, {(DataW-1){1'b0}}};
            out_max_reg <= {1'b0, {(DataW-1){1'b1}}};
        end
        else if (cfg_wr)
        begin
            unique case (cfg_addr)
                pidaw_pkg::REG_GAIN_P:  gain_p_reg  <= pwdata[DataW-1:0];
                pidaw_pkg::REG_GAIN_I:  gain_i_reg  <= pwdata[DataW-1:0];
                pidaw_pkg::REG_GAIN_D:  gain_d_reg  <= pwdata[DataW-1:0];
                pidaw_pkg::REG_OUT_MIN: out_min_reg <= pwdata[DataW-1:0];
                pidaw_pkg::REG_OUT_MAX: out_max_reg <= pwdata[DataW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_addr)
            pidaw_pkg::REG_GAIN_P:  prdata = PdataW'(gain_p_reg);
            pidaw_pkg::REG_GAIN_I:  prdata = PdataW'(gain_i_reg);
            pidaw_pkg::REG_GAIN_D:  prdata = PdataW'(gain_d_reg);
            pidaw_pkg::REG_OUT_MIN: prdata = PdataW'(out_min_reg);
            pidaw_pkg::REG_OUT_MAX: prdata = PdataW'(out_max_reg);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    assign step_err = ErrW'(step.setpoint) - ErrW'(step.measurement);
    assign step_dt  = (step.step_time == '0) ? pidaw_pkg::DT_DEFAULT : step.step_time;

    // integrator += err*dt, saturating
    assign integ_sum = (IntegW+1)'(integ_reg) + (IntegW+1)'(mul_prod);
    assign integ_sat = (integ_sum[IntegW] != integ_sum[IntegW-1])
                     ? (integ_sum[IntegW] ? IntegMin : IntegMax)
                     : integ_sum[IntegW-1:0];

    // integral term clamp in Q.24; upper limit checked first
    assign i_hi_lim   = MulPW'($signed({out_max_reg, 24'd0}));
    assign i_lo_lim   = MulPW'($signed({out_min_reg, 24'd0}));
    assign i_hi       = (mul_prod > i_hi_lim);
    assign i_lo       = (mul_prod < i_lo_lim);
    assign i_lim      = i_hi ? out_max_reg : out_min_reg;
    assign i_lim_abs  = i_lim[DataW-1] ? (~i_lim + DataW'(1)) : i_lim;
    assign gain_i_pos = !gain_i_reg[DataW-1] && (gain_i_reg != '0);

    assign diff   = DiffW'(err_reg) - DiffW'(last_err_reg);
    assign pd_abs = mul_prod[MulPW-1] ? -mul_prod : mul_prod;

    always_comb
    begin
        d8 = $signed({{(SumW-DivNW){1'b0}}, div_q});
        if (quo_neg_reg)
        begin
            d8 = -d8;
        end
    end

    // output clamp in Q.8; lower limit wins when limits cross
    assign max256 = SumW'($signed({out_max_reg, 8'd0}));
    assign min256 = SumW'($signed({out_min_reg, 8'd0}));
    assign sum_hi = (sum_reg > max256);
    assign s1     = sum_hi ? max256 : sum_reg;
    assign sum_lo = (s1 < min256);
    assign s2     = sum_lo ? min256 : s1;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        err_next          = err_reg;
        dt_next           = dt_reg;
        integ_next        = integ_reg;
        last_err_next     = last_err_reg;
        sum_next          = sum_reg;
        quo_neg_next      = quo_neg_reg;
        clr_next          = clr_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        mul_start         = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        div_start         = 1'b0;
        div_n             = '0;
        div_d             = '0;

        unique case (state_reg)
            pidaw_pkg::ST_IDLE:
            begin
                if (step_valid)
                begin
                    if (step.op == pidaw_pkg::OP_CLEAR)
                    begin
                        integ_next    = '0;
                        last_err_next = '0;
                        clr_next      = 1'b1;
                        state_next    = pidaw_pkg::ST_DONE;
                    end
                    else
                    begin
                        err_next   = step_err;
                        dt_next    = step_dt;
                        clr_next   = 1'b0;
                        mul_start  = 1'b1;
                        mul_a      = MulAW'(step_err);
                        mul_b      = {1'b0, step_dt};
                        state_next = pidaw_pkg::ST_MUL_ED;
                    end
                end
            end

            pidaw_pkg::ST_MUL_ED:
            begin
                if (mul_stat.done)
                begin
                    integ_next = integ_sat;
                    mul_start  = 1'b1;
                    mul_a      = integ_sat;
                    mul_b      = MulBW'(gain_i_reg);
                    state_next = pidaw_pkg::ST_MUL_I;
                end
            end

            pidaw_pkg::ST_MUL_I:
            begin
                if (mul_stat.done)
                begin
                    if (i_hi || i_lo)
                    begin
                        sum_next = SumW'($signed({i_lim, 8'd0}));
                        if (gain_i_pos)
                        begin
                            quo_neg_next = i_lim[DataW-1];
                            div_start    = 1'b1;
                            div_n        = {{(DivNW-DataW-24){1'b0}}, i_lim_abs, 24'd0};
                            div_d        = gain_i_reg;
                            state_next   = pidaw_pkg::ST_DIV_I;
                        end
                        else
                        begin
                            integ_next = IntegW'($signed({i_lim, 16'd0}));
                            mul_start  = 1'b1;
                            mul_a      = MulAW'(err_reg);
                            mul_b      = MulBW'(gain_p_reg);
                            state_next = pidaw_pkg::ST_MUL_P;
                        end
                    end
                    else
                    begin
                        sum_next   = SumW'($signed(mul_prod[39:16]));
                        mul_start  = 1'b1;
                        mul_a      = MulAW'(err_reg);
                        mul_b      = MulBW'(gain_p_reg);
                        state_next = pidaw_pkg::ST_MUL_P;
                    end
                end
            end

            pidaw_pkg::ST_DIV_I:
            begin
                if (div_stat.done)
                begin
                    integ_next = quo_neg_reg ? IntegW'(-div_q) : IntegW'(div_q);
                    mul_start  = 1'b1;
                    mul_a      = MulAW'(err_reg);
                    mul_b      = MulBW'(gain_p_reg);
                    state_next = pidaw_pkg::ST_MUL_P;
                end
            end

            pidaw_pkg::ST_MUL_P:
            begin
                if (mul_stat.done)
                begin
                    sum_next   = sum_reg + SumW'($signed(mul_prod[32:0]));
                    mul_start  = 1'b1;
                    mul_a      = MulAW'(diff);
                    mul_b      = MulBW'(gain_d_reg);
                    state_next = pidaw_pkg::ST_MUL_D;
                end
            end

            pidaw_pkg::ST_MUL_D:
            begin
                if (mul_stat.done)
                begin
                    last_err_next = err_reg;
                    quo_neg_next  = mul_prod[MulPW-1];
                    div_start     = 1'b1;
                    div_n         = {pd_abs[31:0], 16'd0};
                    div_d         = dt_reg;
                    state_next    = pidaw_pkg::ST_DIV_D;
                end
            end

            pidaw_pkg::ST_DIV_D:
            begin
                if (div_stat.done)
                begin
                    sum_next   = sum_reg + d8;
                    state_next = pidaw_pkg::ST_DONE;
                end
            end

            pidaw_pkg::ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    if (clr_reg)
                    begin
                        result_next.drive     = '0;
                        result_next.saturated = 1'b0;
                    end
                    else
                    begin
                        result_next.drive     = s2[23:8];
                        result_next.saturated = sum_hi || sum_lo;
                    end
                    result_valid_next = 1'b1;
                    state_next        = pidaw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pidaw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pidaw_pkg::ST_IDLE;
            integ_reg        <= '0;
            last_err_reg     <= '0;
            result_valid_reg <= 1'b0;
            clr_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            integ_reg        <= integ_next;
            last_err_reg     <= last_err_next;
            result_valid_reg <= result_valid_next;
            clr_reg          <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        dt_reg      <= dt_next;
        sum_reg     <= sum_next;
        quo_neg_reg <= quo_neg_next;
        result_reg  <= result_next;
    end

    assign step_stall   = (state_reg != pidaw_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        (step_valid && !step_stall && step.op == pidaw_pkg::OP_CLEAR)
        |=> (integ_reg == '0 && last_err_reg == '0))
        else $error("clear item did not zero integrator and previous error");

    a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pidaw_pkg::ST_IDLE && !step_valid) |=> $stable(integ_reg))
        else $error("integrator changed with no item in progress");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated)
        |-> (result.drive == out_min_reg || result.drive == out_max_reg))
        else $error("saturated drive is not at a limit");

endmodule
